/* src/r2y420_pkg.sv */
// Shared constants, types and helpers for the RGB to YUV 4:2:0 converter.
// No dependencies; imported by rgb_to_yuv420_converter_unit.
package r2y420_pkg;

  // Field widths fixed by the stream format
  localparam int COMP_W        = 8;
  localparam int LUMA_OFF_W    = 24;
  localparam int CHROMA_OFF_W  = 23;
  localparam int CFG_DIM_W     = 13;
  localparam int CFG_IDX_W     = 2;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 96;

  // Default limits for the frame size parameters
  localparam int MAX_WIDTH_DEF  = 4096;
  localparam int MAX_HEIGHT_DEF = 4096;

  // Register reset values
  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic                 LAYOUT_RST = 1'b0;

  // Layout codes
  localparam logic LAYOUT_PLANAR      = 1'b0;
  localparam logic LAYOUT_INTERLEAVED = 1'b1;

  // Register indexes on the config port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_CHROMA_LAYOUT = 2'd2
  } cfg_idx_t;

  // Color sums: Q16 fixed point, signed, wide enough for every RGB value
  localparam int SUM_W = 27;
  typedef logic signed [SUM_W-1:0] csum_t;

  localparam csum_t Y_CR = 27'sd19595;
  localparam csum_t Y_CG = 27'sd38470;
  localparam csum_t Y_CB = 27'sd7471;
  localparam csum_t U_CR = -27'sd9642;
  localparam csum_t U_CG = -27'sd18931;
  localparam csum_t U_CB = 27'sd28574;
  localparam csum_t V_CR = 27'sd40305;
  localparam csum_t V_CG = -27'sd33750;
  localparam csum_t V_CB = -27'sd6554;
  localparam csum_t CHROMA_BIAS = 27'sd8388608; // 128 << 16

  // Weighted sum of one pixel
  function automatic csum_t color_sum(input logic [COMP_W-1:0] r,
                                      input logic [COMP_W-1:0] g,
                                      input logic [COMP_W-1:0] b,
                                      input csum_t cr, input csum_t cg,
                                      input csum_t cb, input csum_t bias);
    csum_t rx, gx, bx;
    rx = csum_t'({1'b0, r});
    gx = csum_t'({1'b0, g});
    bx = csum_t'({1'b0, b});
    return cr * rx + cg * gx + cb * bx + bias;
  endfunction

  // Clamp below at 0, drop 16 fraction bits, clamp above at 255
  function automatic logic [COMP_W-1:0] to_byte(input csum_t s);
    logic [COMP_W-1:0] res;
    if (s[SUM_W-1]) begin
      res = '0;
    end else if (|s[SUM_W-2:24]) begin
      res = 8'hFF;
    end else begin
      res = s[23:16];
    end
    return res;
  endfunction

endpackage

/* src/rgb_to_yuv420_converter_unit.sv */
// RGB to YUV 4:2:0 converter top level: counters, color math, plane offsets.
// Depends on r2y420_pkg.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready  | in_tdata: red, green, blue
//  out_    | out | out_tvalid / out_tready| out_tdata: Y, offsets, U, V; tuser/tlast
//  cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One pixel per clock sustained unless out_ stalls; an in_ beat passes the stage-1
// and output registers. The clock is set by the stage-2 path: three 13x12 offset
// multipliers and the constant-coefficient color sums, each into one adder.
// Reset clears the counters and pipeline valids and loads 640x480, planar.
// A stall on out_ holds both stages; in_tready drops only when both are full.
// cfg_ready is always high.
module rgb_to_yuv420_converter_unit
  import r2y420_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input pixels
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  // results
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [7:0] luma, [31:8] luma_offset, [39:32] u_value, [47:40] v_value,
  // [70:48] u_offset, [93:71] v_offset, [95:94] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] chroma_valid
  output logic                  out_tlast,  // frame_last
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DIM_W-1:0]  cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);                       // width value
  localparam int CW = $clog2(MAX_WIDTH);                           // column
  localparam int HW = $clog2(MAX_HEIGHT + 1);                      // height value
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;   // row
  localparam int PW = RW + WW + 1;                                 // offset math

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [CW-1:0]     col;
    logic [RW-1:0]     row;
    logic [WW-1:0]     width;
    logic              layout;
    logic              cvalid;
    logic              last;
  } s1_pix_t;

  // ---------------- configuration ----------------
  logic [CFG_DIM_W-1:0] frame_width_r, frame_height_r;
  logic                 chroma_layout_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= WIDTH_RST;
      frame_height_r  <= HEIGHT_RST;
      chroma_layout_r <= LAYOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:   frame_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT:  frame_height_r  <= cfg_data;
        CFG_CHROMA_LAYOUT: chroma_layout_r <= cfg_data[0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Effective size: zero acts as one, oversize saturates at the maximum
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(frame_height_r);
    end
  end

  // ---------------- pipeline control ----------------
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_adv;
  logic in_acc;

  assign out_adv   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- raster counters ----------------
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic          row_end, frame_end, cvalid;

  // a counter left past a shrunk limit also ends its row or frame here
  assign row_end   = (32'(col_r) + 32'd1) >= 32'(w_eff);
  assign frame_end = row_end && ((32'(row_r) + 32'd1) >= 32'(h_eff));
  assign cvalid    = !col_r[0] && !row_r[0];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : RW'(row_r + 1'b1);
      end else begin
        col_nxt = CW'(col_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- stage 1: input register ----------------
  s1_pix_t s1_r, s1_nxt;

  always_comb begin
    s1_nxt = s1_r;
    if (in_acc) begin
      s1_nxt.red    = in_tdata[7:0];
      s1_nxt.green  = in_tdata[15:8];
      s1_nxt.blue   = in_tdata[23:16];
      s1_nxt.col    = col_r;
      s1_nxt.row    = row_r;
      s1_nxt.width  = w_eff;
      s1_nxt.layout = chroma_layout_r;
      s1_nxt.cvalid = cvalid;
      s1_nxt.last   = frame_end;
    end
  end

  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

  // ---------------- stage 2: color and offset math ----------------
  logic [COMP_W-1:0]       luma_v, u_v, v_v;
  logic [PW-1:0]           luma_full, planar_full, inter_full, chroma_sel;
  logic [WW-1:0]           half_w;
  logic [RW-1:0]           half_row;
  logic [CW-1:0]           half_col;
  logic [LUMA_OFF_W-1:0]   luma_off;
  logic [CHROMA_OFF_W-1:0] u_off, v_off;
  logic [COMP_W-1:0]       u_out, v_out;

  assign luma_v = to_byte(color_sum(s1_r.red, s1_r.green, s1_r.blue,
                                    Y_CR, Y_CG, Y_CB, '0));
  assign u_v    = to_byte(color_sum(s1_r.red, s1_r.green, s1_r.blue,
                                    U_CR, U_CG, U_CB, CHROMA_BIAS));
  assign v_v    = to_byte(color_sum(s1_r.red, s1_r.green, s1_r.blue,
                                    V_CR, V_CG, V_CB, CHROMA_BIAS));

  assign half_w   = s1_r.width >> 1;
  assign half_row = s1_r.row >> 1;
  assign half_col = s1_r.col >> 1;

  assign luma_full   = PW'(s1_r.row) * PW'(s1_r.width) + PW'(s1_r.col);
  assign planar_full = PW'(half_row) * PW'(half_w) + PW'(half_col);
  assign inter_full  = PW'(half_row) * PW'(s1_r.width) + PW'(s1_r.col);

  assign luma_off   = LUMA_OFF_W'(luma_full);
  assign chroma_sel = (s1_r.layout == LAYOUT_INTERLEAVED) ? inter_full : planar_full;

  // chroma fields read as zero on pixels that carry no chroma
  always_comb begin
    u_out = '0;
    v_out = '0;
    u_off = '0;
    v_off = '0;
    if (s1_r.cvalid) begin
      u_out = u_v;
      v_out = v_v;
      u_off = CHROMA_OFF_W'(chroma_sel);
      v_off = (s1_r.layout == LAYOUT_INTERLEAVED) ?
              CHROMA_OFF_W'(chroma_sel + 1'b1) : CHROMA_OFF_W'(chroma_sel);
    end
  end

  // ---------------- output register ----------------
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  always_comb begin
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    if (out_adv && s1_valid_r) begin
      out_data_nxt = {2'b00, v_off, u_off, v_out, u_out, luma_off, luma_v};
      out_user_nxt = s1_r.cvalid;
      out_last_nxt = s1_r.last;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // ---------------- assertions ----------------
  // the last pixel of a frame sends both counters home
  a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && frame_end) |=> (col_r == '0 && row_r == '0))
    else $error("counters not cleared after frame end");

  // a pixel parked in stage 1 stays put while the output is stalled
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 changed under output stall");

  // no-chroma beats carry zero chroma values and offsets
  a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[93:32] == '0))
    else $error("chroma fields nonzero on a luma-only beat");

endmodule
